@@ src/bcp_pkg.sv @@
package bcp_pkg;

  // Change code per turn, also the two halves of a table entry
  typedef enum logic [1:0] {
    CODE_SAME   = 2'd0,
    CODE_CHANGE = 2'd1,
    CODE_SHRUG  = 2'd2
  } change_code_t;

  // Outcome of a turn from the player's side
  typedef enum logic [1:0] {
    OUT_LOSE  = 2'd0,
    OUT_WIN   = 2'd1,
    OUT_UNSET = 2'd2
  } outcome_t;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned IdxW       = $clog2(TableDepth);

  // entry layout: [1:0] older code, [3:2] newer code
  typedef logic [3:0] entry_t;
  localparam entry_t EntryReset = {CODE_SHRUG, CODE_SHRUG};

endpackage

@@ src/bcp_if.sv @@
// Input channel: one turn per word
interface bcp_in_if;
  logic valid;
  logic ready;
  logic player_bit;
  logic random_bit;

  modport source (output valid, output player_bit, output random_bit, input ready);
  modport sink   (input valid, input player_bit, input random_bit, output ready);
endinterface

// Result channel: one word per turn
interface bcp_out_if;
  logic valid;
  logic ready;
  logic player_won;
  logic next_prediction;
  logic guessed;

  modport source (output valid, output player_won, output next_prediction, output guessed,
                  input ready);
  modport sink   (input valid, input player_won, input next_prediction, input guessed,
                  output ready);
endinterface

@@ src/binary_choice_predictor_unit.sv @@
// Binary choice predictor (mind-reading machine). Each word on in_chan is one
// turn: the player's bit and a spare coin flip. The block scores the turn
// against the prediction it holds, classes the turn as same or changed, trains
// an 8-entry history table indexed by (outcome two turns back, last change,
// last outcome) and returns on out_chan whether the player won, the
// prediction for the next turn and whether that prediction is a coin flip.
// Throughput is one word per clock while the output is not stalled; the result
// is loaded into the output register at acceptance. The rate is set by the table
// update and lookup, which share one entry read with a bypass for the case
// where the new context equals the one just trained. in_chan.ready stays high
// while the output register is empty or being drained. cfg_wdata written with
// cfg_we sets the prediction held before the first turn; once play has begun
// a write has no effect on play, and reset clears the held prediction to 0.
module binary_choice_predictor_unit (
  input  logic       clk,
  input  logic       rst_n,
  bcp_in_if.sink     in_chan,
  bcp_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import bcp_pkg::*;

  // turn state
  entry_t       tbl_r [TableDepth];
  outcome_t     older_r;
  change_code_t last_change_r;
  outcome_t     last_outcome_r;
  logic         prev_choice_r;
  logic         prev_valid_r;
  logic         cur_pred_r;

  // output register
  logic         out_valid_r;
  logic         out_won_r;
  logic         out_pred_r;
  logic         out_guess_r;

  logic         in_acc;
  logic         choice;
  logic         won;
  change_code_t change;
  logic         old_ok;
  logic         new_ok;
  logic [IdxW-1:0] old_idx;
  logic [IdxW-1:0] new_idx;
  entry_t       look;
  entry_t       look_byp;
  logic         pred_nxt;
  logic         guess_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign choice        = in_chan.player_bit;

  always_comb begin
    won    = choice != cur_pred_r;
    change = (prev_valid_r && choice == prev_choice_r) ? CODE_SAME : CODE_CHANGE;

    // context before this turn: trained only when every part is known
    old_ok  = (older_r == OUT_LOSE || older_r == OUT_WIN) &&
              (last_change_r == CODE_SAME || last_change_r == CODE_CHANGE) &&
              (last_outcome_r == OUT_LOSE || last_outcome_r == OUT_WIN);
    old_idx = {older_r[0], last_change_r[0], last_outcome_r[0]};

    // context after this turn: change and outcome are always known now
    new_ok  = last_outcome_r == OUT_LOSE || last_outcome_r == OUT_WIN;
    new_idx = {last_outcome_r[0], change[0], won};

    look = tbl_r[new_idx];
    // same entry as the one being trained: forward the shifted value
    if (old_ok && old_idx == new_idx) begin
      look_byp = {change, look[3:2]};
    end else begin
      look_byp = look;
    end

    if (new_ok && look_byp[1:0] == look_byp[3:2] && look_byp[1:0] == CODE_SAME) begin
      pred_nxt  = choice;
      guess_nxt = 1'b0;
    end else if (new_ok && look_byp[1:0] == look_byp[3:2] &&
                 look_byp[1:0] == CODE_CHANGE) begin
      pred_nxt  = ~choice;
      guess_nxt = 1'b0;
    end else begin
      pred_nxt  = in_chan.random_bit;
      guess_nxt = 1'b1;
    end
  end

  // history table: each entry shifts in the change when its context is hit
  always_ff @(posedge clk) begin
    for (int i = 0; i < TableDepth; i++) begin
      if (!rst_n) begin
        tbl_r[i] <= EntryReset;
      end else if (in_acc && old_ok && old_idx == IdxW'(i)) begin
        tbl_r[i] <= {change, tbl_r[i][3:2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r        <= OUT_UNSET;
      last_change_r  <= CODE_SHRUG;
      last_outcome_r <= OUT_UNSET;
      prev_choice_r  <= 1'b0;
      prev_valid_r   <= 1'b0;
      cur_pred_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        older_r        <= last_outcome_r;
        last_change_r  <= change;
        last_outcome_r <= won ? OUT_WIN : OUT_LOSE;
        prev_choice_r  <= choice;
        prev_valid_r   <= 1'b1;
        cur_pred_r     <= pred_nxt;
      end else if (cfg_we && !prev_valid_r) begin
        // before the first turn the register also loads the held prediction
        cur_pred_r <= cfg_wdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_won_r   <= won;
      out_pred_r  <= pred_nxt;
      out_guess_r <= guess_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.player_won      = out_won_r;
  assign out_chan.next_prediction = out_pred_r;
  assign out_chan.guessed         = out_guess_r;

endmodule

@@ src/bcp_checker.sv @@
module bcp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_won,
  input logic out_pred,
  input logic out_guess
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // every accepted turn yields a result word next cycle
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted turn produced no result word");

  // a stalled result blocks the input side, so no word is lost
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result word stalled");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_won) && $stable(out_pred) &&
    $stable(out_guess))
    else $error("stalled result word changed");

endmodule

bind binary_choice_predictor_unit bcp_checker u_bcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_won   (out_chan.player_won),
  .out_pred  (out_chan.next_prediction),
  .out_guess (out_chan.guessed)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bcp_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned PrintCap   = 100;

  typedef struct packed {
    logic choice;
    logic coin;
  } turn_t;

  typedef struct packed {
    logic won;
    logic pred;
    logic guessed;
  } verdict_t;

  typedef enum int unsigned {
    PAT_STEADY,
    PAT_ALTERNATE,
    PAT_TRIPLET,
    PAT_NOISE
  } pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  bcp_in_if  in_chan ();
  bcp_out_if out_chan ();

  binary_choice_predictor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Stimulus and scoreboard storage
  turn_t       pending_turns [$];
  verdict_t    awaited_verdicts [$];
  int unsigned turns_queued;
  int unsigned turns_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Idling knobs, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        long_hold_req;
  logic        long_hold_done;
  int unsigned hold_left;

  // Own copy of the predictor state
  logic         held_pred;
  logic         last_choice;
  logic         seen_first;
  outcome_t     outcome_two_back;
  outcome_t     outcome_last;
  change_code_t change_last;
  change_code_t hist_older [TableDepth];
  change_code_t hist_newer [TableDepth];

  // Context is usable only when no part of it is unset or shrug
  function automatic bit context_known(output logic [IdxW-1:0] idx);
    idx = '0;
    if (outcome_two_back == OUT_UNSET || outcome_last == OUT_UNSET ||
        change_last == CODE_SHRUG)
      return 1'b0;
    idx = {outcome_two_back[0], change_last[0], outcome_last[0]};
    return 1'b1;
  endfunction

  // Scores one turn, trains the history and works out the next prediction
  function automatic verdict_t score_turn(turn_t t);
    verdict_t        v;
    change_code_t    chg;
    change_code_t    a;
    change_code_t    b;
    logic [IdxW-1:0] idx;
    v.won = (t.choice != held_pred);
    chg = (seen_first && t.choice == last_choice) ? CODE_SAME : CODE_CHANGE;
    if (context_known(idx)) begin
      hist_older[idx] = hist_newer[idx];
      hist_newer[idx] = chg;
    end
    last_choice      = t.choice;
    seen_first       = 1'b1;
    outcome_two_back = outcome_last;
    change_last      = chg;
    outcome_last     = v.won ? OUT_WIN : OUT_LOSE;
    a = CODE_SHRUG;
    b = CODE_SHRUG;
    if (context_known(idx)) begin
      a = hist_older[idx];
      b = hist_newer[idx];
    end
    if (a == b && a == CODE_SAME) begin
      held_pred = t.choice;
      v.guessed = 1'b0;
    end else if (a == b && a == CODE_CHANGE) begin
      held_pred = ~t.choice;
      v.guessed = 1'b0;
    end else begin
      held_pred = t.coin;
      v.guessed = 1'b1;
    end
    v.pred = held_pred;
    return v;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < PrintCap)
      $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_turn(logic choice, logic coin);
    turn_t t;
    t.choice = choice;
    t.coin   = coin;
    pending_turns.push_back(t);
    turns_queued++;
  endtask

  // Random turns, mostly patterned runs so the table actually trains
  task automatic queue_turns(int unsigned count);
    pattern_t    pat;
    int unsigned run;
    int unsigned k;
    int unsigned pick;
    logic        b;
    logic        c;
    while (count > 0) begin
      pick = $urandom_range(9);
      if (pick < 4)      pat = PAT_STEADY;
      else if (pick < 7) pat = PAT_ALTERNATE;
      else if (pick < 8) pat = PAT_TRIPLET;
      else               pat = PAT_NOISE;
      run = $urandom_range(14, 3);
      b   = 1'($urandom_range(1));
      for (k = 0; k < run && count > 0; k++) begin
        case (pat)
          PAT_STEADY:    c = b;
          PAT_ALTERNATE: c = b ^ k[0];
          PAT_TRIPLET:   c = b ^ ((k % 3) == 2);
          default:       c = 1'($urandom_range(1));
        endcase
        // odd slip so patterns are not perfect
        if ($urandom_range(15) == 0)
          c = ~c;
        push_turn(c, 1'($urandom_range(1)));
        count--;
      end
    end
  endtask

  task automatic wait_drained();
    while (turns_taken != turns_queued || awaited_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Only called with nothing in flight; before the first turn it also
  // loads the held prediction
  task automatic write_setting(logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    if (!seen_first)
      held_pred = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: one word per ready cycle from pending_turns, idling at random
  always @(posedge clk) begin
    turn_t t;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        t.choice = in_chan.player_bit;
        t.coin   = in_chan.random_bit;
        awaited_verdicts.push_back(score_turn(t));
        turns_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_turns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          t = pending_turns.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.player_bit <= t.choice;
          in_chan.random_bit <= t.coin;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest expectation
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    logic     rdy;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      long_hold_done <= 1'b0;
      hold_left      <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.won     = out_chan.player_won;
        got.pred    = out_chan.next_prediction;
        got.guessed = out_chan.guessed;
        if (awaited_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing expected: %b", got));
        end else begin
          want = awaited_verdicts.pop_front();
          if (got.won !== want.won)
            flag_mismatch($sformatf("player_won got %b want %b", got.won, want.won));
          if (got.pred !== want.pred)
            flag_mismatch($sformatf("next_prediction got %b want %b",
                                    got.pred, want.pred));
          if (got.guessed !== want.guessed)
            flag_mismatch($sformatf("guessed got %b want %b",
                                    got.guessed, want.guessed));
        end
      end
      // a long hold-off, once, so the block backs up and drops in_chan.ready
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left      <= LongHold;
        rdy = 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(99) >= recv_stall_pct);
      end
      out_chan.ready <= rdy;
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    in_chan.valid         = 1'b0;
    in_chan.player_bit    = 1'b0;
    in_chan.random_bit    = 1'b0;
    out_chan.ready        = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    long_hold_req         = 1'b0;
    turns_queued          = 0;
    turns_taken           = 0;
    mismatches            = 0;
    quiet_cycles          = 0;

    // predictor reset state
    held_pred        = 1'b0;
    last_choice      = 1'b0;
    seen_first       = 1'b0;
    outcome_two_back = OUT_UNSET;
    outcome_last     = OUT_UNSET;
    change_last      = CODE_SHRUG;
    for (k = 0; k < TableDepth; k++) begin
      hist_older[k] = CODE_SHRUG;
      hist_newer[k] = CODE_SHRUG;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // both register values before play; the last one is held for turn one
    write_setting(1'b0);
    write_setting(1'b1);

    // Directed: first turn, incomplete contexts, a steady run to learn
    // "same", an alternating run to learn "change", then all bit pairs
    for (k = 0; k < 8; k++)
      push_turn(1'b0, k[0]);
    for (k = 0; k < 8; k++)
      push_turn(k[0], ~k[0]);
    push_turn(1'b1, 1'b1);
    push_turn(1'b1, 1'b0);
    push_turn(1'b0, 1'b1);
    push_turn(1'b0, 1'b0);
    push_turn(1'b1, 1'b1);
    push_turn(1'b0, 1'b0);
    wait_drained();

    // random, no idling; post-play writes have no effect on the register
    write_setting(1'b0);
    queue_turns(150);
    wait_drained();

    write_setting(1'b1);
    send_idle_pct <= 57;
    queue_turns(150);
    wait_drained();

    write_setting(1'b0);
    send_idle_pct  <= 0;
    recv_stall_pct <= 57;
    queue_turns(150);
    wait_drained();

    write_setting(1'b1);
    send_idle_pct  <= 23;
    recv_stall_pct <= 23;
    queue_turns(150);
    wait_drained();

    // back-pressure: receiver holds off while the sender keeps offering
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    long_hold_req  <= 1'b1;
    queue_turns(60);
    wait_drained();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && awaited_verdicts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
